// File: design/hvc_pkg.sv
`default_nettype none

package hvc_pkg;

	// field widths
	localparam int ELEV_W     = 24;
	localparam int SCALE_W    = 16;
	localparam int SCALE_FRAC = 8;
	localparam int CELL_W     = 16;
	localparam int GRID_W     = 13;
	localparam int IDX_W      = 12;
	localparam int POS_W      = 29;
	localparam int Y_W        = 32;
	localparam int CH_W       = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// default for the grid dimension clamp
	localparam int MAX_GRID_DIM_DEF = 4096;

	// color datapath widths
	localparam int DIFF_W = ELEV_W + 1;
	localparam int D4_W   = ELEV_W + 4;
	localparam int NUM_W  = ELEV_W + 3;
	localparam int DEN_W  = ELEV_W + 1;
	localparam int N_W    = NUM_W + 10;
	localparam int REM_W  = DEN_W + CH_W;

	// pipeline shape
	localparam int DIV_STEPS   = CH_W;
	localparam int GEOM_STAGES = 4;
	localparam int PIPE_DEPTH  = 6 + DIV_STEPS;

	localparam logic [CH_W-1:0] CH_GRAY = 8'd128;
	localparam logic [CH_W-1:0] CH_MAX  = 8'd255;
	localparam logic [9:0] RAMP_GAIN    = 10'd510;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_ELEV,
		REG_MAX_ELEV,
		REG_VSCALE,
		REG_CELL_WIDTH,
		REG_CELL_HEIGHT,
		REG_GRID_COLS,
		REG_GRID_ROWS,
		REG_FLIP_Z
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEG_BLUE_CYAN,
		SEG_CYAN_GREEN,
		SEG_GREEN_YELLOW,
		SEG_YELLOW_RED
	} seg_t;

	// side information that travels with the divider
	typedef struct packed {
		logic gray;
		seg_t seg;
		logic sat;
	} div_tag_t;

endpackage

`default_nettype wire

// File: design/hvc_geom.sv
`default_nettype none

module hvc_geom #(
	parameter int MAX_GRID_DIM = hvc_pkg::MAX_GRID_DIM_DEF
) (
	input  logic                                   clk,
	input  logic signed [hvc_pkg::ELEV_W-1:0]      elevation,
	input  logic                                   no_data,
	input  logic        [hvc_pkg::IDX_W-1:0]       row_index,
	input  logic        [hvc_pkg::IDX_W-1:0]       col_index,
	input  logic signed [hvc_pkg::ELEV_W-1:0]      min_elev,
	input  logic        [hvc_pkg::SCALE_W-1:0]     vertical_scale,
	input  logic        [hvc_pkg::CELL_W-1:0]      cell_width,
	input  logic        [hvc_pkg::CELL_W-1:0]      cell_height,
	input  logic        [hvc_pkg::GRID_W-1:0]      grid_cols,
	input  logic        [hvc_pkg::GRID_W-1:0]      grid_rows,
	input  logic                                   flip_z,
	output logic signed [hvc_pkg::POS_W-1:0]       pos_x,
	output logic signed [hvc_pkg::Y_W-1:0]         pos_y,
	output logic signed [hvc_pkg::POS_W-1:0]       pos_z
);

	import hvc_pkg::*;

	localparam int OFS_W  = GRID_W + 2;
	localparam int PROD_W = OFS_W + CELL_W + 1;
	localparam int P_W    = ELEV_W + SCALE_W + 1;
	localparam int DELAY  = PIPE_DEPTH - GEOM_STAGES;

	localparam logic signed [P_W-1:0]    Y_ROUND = P_W'(1 << (SCALE_FRAC - 1));
	localparam logic signed [PROD_W-1:0] POS_HI  = PROD_W'((2 ** (POS_W - 1)) - 1);
	localparam logic signed [PROD_W-1:0] POS_LO  = -PROD_W'(2 ** (POS_W - 1));

	logic [31:0]              cols_ext, rows_ext;
	logic [GRID_W-1:0]        gdim_c, gdim_r;

	logic signed [OFS_W-1:0]  dc_s1, dr_s1;
	logic signed [ELEV_W-1:0] h_s1;
	logic signed [PROD_W-1:0] x_s2, z_s2;
	logic signed [P_W-1:0]    p_s2;
	logic signed [PROD_W-1:0] x_s3, z_s3;
	logic signed [Y_W-1:0]    y_s3;
	logic signed [POS_W-1:0]  x_s4, z_s4;
	logic signed [Y_W-1:0]    y_s4;

	logic signed [POS_W-1:0]  x_line_q [DELAY];
	logic signed [POS_W-1:0]  z_line_q [DELAY];
	logic signed [Y_W-1:0]    y_line_q [DELAY];

	// oversized grid registers act as the largest grid
	always_comb begin
		cols_ext = 32'(grid_cols);
		rows_ext = 32'(grid_rows);
		gdim_c = (cols_ext > 32'(MAX_GRID_DIM)) ? GRID_W'(MAX_GRID_DIM) : grid_cols;
		gdim_r = (rows_ext > 32'(MAX_GRID_DIM)) ? GRID_W'(MAX_GRID_DIM) : grid_rows;
	end

	// stage 1: centered offsets in half cells, height source
	always_ff @(posedge clk) begin
		dc_s1 <= $signed(OFS_W'({col_index, 1'b0})) - $signed(OFS_W'(gdim_c));
		dr_s1 <= $signed(OFS_W'({row_index, 1'b0})) - $signed(OFS_W'(gdim_r));
		h_s1  <= no_data ? min_elev : elevation;
	end

	// stage 2: scale by cell size and vertical factor
	always_ff @(posedge clk) begin
		x_s2 <= dc_s1 * $signed({1'b0, cell_width});
		z_s2 <= dr_s1 * $signed({1'b0, cell_height});
		p_s2 <= h_s1 * $signed({1'b0, vertical_scale});
	end

	// stage 3: orientation of z, round y to nearest with ties upward
	always_ff @(posedge clk) begin
		x_s3 <= x_s2;
		z_s3 <= flip_z ? -z_s2 : z_s2;
		y_s3 <= Y_W'((p_s2 + Y_ROUND) >>> SCALE_FRAC);
	end

	// stage 4: clamp positions to the output range
	always_ff @(posedge clk) begin
		if (x_s3 > POS_HI) begin
			x_s4 <= POS_W'(POS_HI);
		end else if (x_s3 < POS_LO) begin
			x_s4 <= POS_W'(POS_LO);
		end else begin
			x_s4 <= POS_W'(x_s3);
		end
		if (z_s3 > POS_HI) begin
			z_s4 <= POS_W'(POS_HI);
		end else if (z_s3 < POS_LO) begin
			z_s4 <= POS_W'(POS_LO);
		end else begin
			z_s4 <= POS_W'(z_s3);
		end
		y_s4 <= y_s3;
	end

	// align with the color pipeline
	always_ff @(posedge clk) begin
		x_line_q[0] <= x_s4;
		z_line_q[0] <= z_s4;
		y_line_q[0] <= y_s4;
		for (int i = 1; i < DELAY; i++) begin
			x_line_q[i] <= x_line_q[i-1];
			z_line_q[i] <= z_line_q[i-1];
			y_line_q[i] <= y_line_q[i-1];
		end
	end

	assign pos_x = x_line_q[DELAY-1];
	assign pos_y = y_line_q[DELAY-1];
	assign pos_z = z_line_q[DELAY-1];

endmodule

`default_nettype wire

// File: design/hvc_div_stage.sv
`default_nettype none

module hvc_div_stage #(
	parameter int SHIFT = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid,
	input  hvc_pkg::div_tag_t                 tag,
	input  logic [hvc_pkg::DEN_W-1:0]         den,
	input  logic [hvc_pkg::REM_W-1:0]         rem,
	input  logic [hvc_pkg::CH_W-1:0]          quo,
	output logic                              valid_s1,
	output hvc_pkg::div_tag_t                 tag_s1,
	output logic [hvc_pkg::DEN_W-1:0]         den_s1,
	output logic [hvc_pkg::REM_W-1:0]         rem_s1,
	output logic [hvc_pkg::CH_W-1:0]          quo_s1
);

	import hvc_pkg::*;

	logic [REM_W-1:0] trial;
	logic             fit;

	// one restoring step: compare against the shifted divisor
	always_comb begin
		trial = REM_W'(den) << SHIFT;
		fit   = (rem >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= tag;
		den_s1 <= den;
		rem_s1 <= fit ? (rem - trial) : rem;
		quo_s1 <= {quo[CH_W-2:0], fit};
	end

endmodule

`default_nettype wire

// File: design/hvc_color.sv
`default_nettype none

module hvc_color (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid,
	input  logic signed [hvc_pkg::ELEV_W-1:0]   elevation,
	input  logic                                no_data,
	input  logic signed [hvc_pkg::ELEV_W-1:0]   min_elev,
	input  logic signed [hvc_pkg::ELEV_W-1:0]   max_elev,
	output logic                                valid_s14,
	output logic        [hvc_pkg::CH_W-1:0]     red_s14,
	output logic        [hvc_pkg::CH_W-1:0]     green_s14,
	output logic        [hvc_pkg::CH_W-1:0]     blue_s14
);

	import hvc_pkg::*;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DIFF_W-1:0] d_s1, rng_s1;
	logic                     nd_s1;

	logic                     gray_s2;
	logic signed [D4_W-1:0]   d4_s2, r1_s2, r2_s2, r3_s2;
	logic [DEN_W-1:0]         den_s2;

	seg_t                     seg_c;
	logic signed [D4_W-1:0]   num_c;
	logic                     gray_s3;
	seg_t                     seg_s3;
	logic signed [D4_W-1:0]   num_s3;
	logic [DEN_W-1:0]         den_s3;

	logic [NUM_W-1:0]         numu_c;
	logic                     gray_s4;
	seg_t                     seg_s4;
	logic [N_W-1:0]           big_s4;
	logic [DEN_W-1:0]         den_s4;

	div_tag_t                 tag_s5;
	logic [DEN_W-1:0]         den_s5;
	logic [REM_W-1:0]         rem_s5;

	logic                     dv_valid [DIV_STEPS+1];
	div_tag_t                 dv_tag   [DIV_STEPS+1];
	logic [DEN_W-1:0]         dv_den   [DIV_STEPS+1];
	logic [REM_W-1:0]         dv_rem   [DIV_STEPS+1];
	logic [CH_W-1:0]          dv_quo   [DIV_STEPS+1];

	logic [CH_W-1:0]          ramp_c;
	div_tag_t                 fin_tag;

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: offset into the range and range width
	always_ff @(posedge clk) begin
		d_s1   <= $signed({elevation[ELEV_W-1], elevation}) - $signed({min_elev[ELEV_W-1], min_elev});
		rng_s1 <= $signed({max_elev[ELEV_W-1], max_elev}) - $signed({min_elev[ELEV_W-1], min_elev});
		nd_s1  <= no_data;
	end

	// stage 2: segment boundaries, gray for no-data or empty range
	always_ff @(posedge clk) begin
		gray_s2 <= nd_s1 || rng_s1[DIFF_W-1] || (rng_s1 == '0);
		d4_s2   <= D4_W'(d_s1) <<< 2;
		r1_s2   <= D4_W'(rng_s1);
		r2_s2   <= D4_W'(rng_s1) <<< 1;
		r3_s2   <= D4_W'(rng_s1) + (D4_W'(rng_s1) <<< 1);
		den_s2  <= {rng_s1[DIFF_W-2:0], 1'b0};
	end

	// segment select and position within the segment
	always_comb begin
		seg_c = SEG_YELLOW_RED;
		num_c = d4_s2 - r3_s2;
		if (d4_s2 < r1_s2) begin
			seg_c = SEG_BLUE_CYAN;
			num_c = d4_s2;
		end else if (d4_s2 < r2_s2) begin
			seg_c = SEG_CYAN_GREEN;
			num_c = d4_s2 - r1_s2;
		end else if (d4_s2 < r3_s2) begin
			seg_c = SEG_GREEN_YELLOW;
			num_c = d4_s2 - r2_s2;
		end
	end

	// stage 3
	always_ff @(posedge clk) begin
		gray_s3 <= gray_s2;
		seg_s3  <= seg_c;
		num_s3  <= num_c;
		den_s3  <= den_s2;
	end

	// stage 4: dividend 510*num + range, negative positions ramp from zero
	always_comb begin
		numu_c = (!num_s3[D4_W-1] && (num_s3 != '0)) ? NUM_W'(num_s3) : '0;
	end

	always_ff @(posedge clk) begin
		gray_s4 <= gray_s3;
		seg_s4  <= seg_s3;
		big_s4  <= N_W'(numu_c) * N_W'(RAMP_GAIN) + N_W'(den_s3[DEN_W-1:1]);
		den_s4  <= den_s3;
	end

	// stage 5: quotient above 255 saturates
	always_ff @(posedge clk) begin
		tag_s5.gray <= gray_s4;
		tag_s5.seg  <= seg_s4;
		tag_s5.sat  <= (big_s4 >= (N_W'(den_s4) << CH_W));
		den_s5      <= den_s4;
		rem_s5      <= REM_W'(big_s4);
	end

	// divider, one quotient bit per stage, msb first
	assign dv_valid[0] = v_s5;
	assign dv_tag[0]   = tag_s5;
	assign dv_den[0]   = den_s5;
	assign dv_rem[0]   = rem_s5;
	assign dv_quo[0]   = '0;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		hvc_div_stage #(
			.SHIFT(DIV_STEPS - 1 - k)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid    (dv_valid[k]),
			.tag      (dv_tag[k]),
			.den      (dv_den[k]),
			.rem      (dv_rem[k]),
			.quo      (dv_quo[k]),
			.valid_s1 (dv_valid[k+1]),
			.tag_s1   (dv_tag[k+1]),
			.den_s1   (dv_den[k+1]),
			.rem_s1   (dv_rem[k+1]),
			.quo_s1   (dv_quo[k+1])
		);
	end

	// final stage: map the ramp value onto the segment colors
	always_comb begin
		fin_tag = dv_tag[DIV_STEPS];
		ramp_c  = fin_tag.sat ? CH_MAX : dv_quo[DIV_STEPS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s14 <= 1'b0;
		end else begin
			valid_s14 <= dv_valid[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (fin_tag.gray) begin
			red_s14   <= CH_GRAY;
			green_s14 <= CH_GRAY;
			blue_s14  <= CH_GRAY;
		end else begin
			case (fin_tag.seg)
				SEG_BLUE_CYAN: begin
					red_s14   <= '0;
					green_s14 <= ramp_c;
					blue_s14  <= CH_MAX;
				end
				SEG_CYAN_GREEN: begin
					red_s14   <= '0;
					green_s14 <= CH_MAX;
					blue_s14  <= CH_MAX - ramp_c;
				end
				SEG_GREEN_YELLOW: begin
					red_s14   <= ramp_c;
					green_s14 <= CH_MAX;
					blue_s14  <= '0;
				end
				SEG_YELLOW_RED: begin
					red_s14   <= CH_MAX;
					green_s14 <= CH_MAX - ramp_c;
					blue_s14  <= '0;
				end
				default: begin
					red_s14   <= CH_GRAY;
					green_s14 <= CH_GRAY;
					blue_s14  <= CH_GRAY;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// an unsaturated division leaves a remainder below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_valid[DIV_STEPS] && !dv_tag[DIV_STEPS].sat && !dv_tag[DIV_STEPS].gray)
		|-> (dv_rem[DIV_STEPS] < REM_W'(dv_den[DIV_STEPS])))
		else $error("divider remainder not below divisor");

	// every ramp color pins green, or red and blue at opposite ends, or is gray
	a_ramp_shape: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s14 |-> ((red_s14 == CH_GRAY && green_s14 == CH_GRAY && blue_s14 == CH_GRAY)
			|| (green_s14 == CH_MAX)
			|| (red_s14 == '0 && blue_s14 == CH_MAX)
			|| (red_s14 == CH_MAX && blue_s14 == '0)))
		else $error("color off the ramp");
`endif

endmodule

`default_nettype wire

// File: design/heightmap_vertex_color.sv
`default_nettype none

// Per-sample vertex position and elevation color for a height grid.
// Input channel: an item (elevation, no_data, row_index, col_index) is taken at
// a rising edge where start is high and busy is low. busy is low in normal
// operation, so one item can be taken every cycle.
// Result channel: done is high for exactly one cycle with pos_x, pos_y, pos_z,
// red, green and blue; the receiver takes the result in that cycle and cannot
// stall it.
// Throughput is one item per cycle. The result of each item passes through the
// pipeline below before it reaches the ports.
// The depth is set by the color ramp: a 5-stage front end followed by an
// 8-stage restoring divider (one quotient bit per stage) and an output stage.
// Configuration: wr_en, wr_index, wr_data write one register per cycle; write
// only while no item is in flight.
// Reset: arst_n clears all valid bits and loads register defaults; busy is high
// during reset and is cleared by the next clock edge after release.
module heightmap_vertex_color #(
	parameter int MAX_GRID_DIM = hvc_pkg::MAX_GRID_DIM_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [hvc_pkg::ELEV_W-1:0]      elevation,
	input  logic                                   no_data,
	input  logic        [hvc_pkg::IDX_W-1:0]       row_index,
	input  logic        [hvc_pkg::IDX_W-1:0]       col_index,
	input  logic                                   wr_en,
	input  logic        [hvc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic        [hvc_pkg::CFG_DATA_W-1:0]  wr_data,
	output logic                                   done,
	output logic signed [hvc_pkg::POS_W-1:0]       pos_x,
	output logic signed [hvc_pkg::Y_W-1:0]         pos_y,
	output logic signed [hvc_pkg::POS_W-1:0]       pos_z,
	output logic        [hvc_pkg::CH_W-1:0]        red,
	output logic        [hvc_pkg::CH_W-1:0]        green,
	output logic        [hvc_pkg::CH_W-1:0]        blue
);

	import hvc_pkg::*;

	logic signed [ELEV_W-1:0] min_elev_q, max_elev_q;
	logic [SCALE_W-1:0]       vscale_q;
	logic [CELL_W-1:0]        cell_width_q, cell_height_q;
	logic [GRID_W-1:0]        grid_cols_q, grid_rows_q;
	logic                     flip_z_q;
	logic                     busy_q;
	logic                     accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_elev_q    <= '0;
			max_elev_q    <= '0;
			vscale_q      <= SCALE_W'(256);
			cell_width_q  <= CELL_W'(100);
			cell_height_q <= CELL_W'(100);
			grid_cols_q   <= GRID_W'(1);
			grid_rows_q   <= GRID_W'(1);
			flip_z_q      <= 1'b0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_MIN_ELEV:    min_elev_q    <= $signed(wr_data[ELEV_W-1:0]);
				REG_MAX_ELEV:    max_elev_q    <= $signed(wr_data[ELEV_W-1:0]);
				REG_VSCALE:      vscale_q      <= wr_data[SCALE_W-1:0];
				REG_CELL_WIDTH:  cell_width_q  <= wr_data[CELL_W-1:0];
				REG_CELL_HEIGHT: cell_height_q <= wr_data[CELL_W-1:0];
				REG_GRID_COLS:   grid_cols_q   <= wr_data[GRID_W-1:0];
				REG_GRID_ROWS:   grid_rows_q   <= wr_data[GRID_W-1:0];
				REG_FLIP_Z:      flip_z_q      <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// held off only while coming out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// position datapath
	hvc_geom #(
		.MAX_GRID_DIM(MAX_GRID_DIM)
	) u_geom (
		.clk            (clk),
		.elevation      (elevation),
		.no_data        (no_data),
		.row_index      (row_index),
		.col_index      (col_index),
		.min_elev       (min_elev_q),
		.vertical_scale (vscale_q),
		.cell_width     (cell_width_q),
		.cell_height    (cell_height_q),
		.grid_cols      (grid_cols_q),
		.grid_rows      (grid_rows_q),
		.flip_z         (flip_z_q),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z)
	);

	// color ramp datapath, carries the item valid
	hvc_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (accept),
		.elevation (elevation),
		.no_data   (no_data),
		.min_elev  (min_elev_q),
		.max_elev  (max_elev_q),
		.valid_s14 (done),
		.red_s14   (red),
		.green_s14 (green),
		.blue_s14  (blue)
	);

`ifndef SYNTHESIS
	// every result traces back to an item taken earlier through the pipeline
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_DEPTH))
		else $error("result without a matching item");
`endif

endmodule

`default_nettype wire
